>>> hdl/bonc_pkg.sv
// Shared types and constants for the box overlap negative check block.
// No dependencies; compiled first.
package bonc_pkg;

	localparam int OPCODE_W    = 2;
	localparam int BOX_COUNT_W = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

>>> hdl/bonc_if.sv
// Valid/ready channels of the box overlap negative check block.
// Depends on bonc_pkg.
interface bonc_cmd_if import bonc_pkg::*; #(
	parameter int COORD_BITS = 13
) ();
	logic                  valid;
	logic                  ready;
	logic [OPCODE_W-1:0]   opcode;
	logic [COORD_BITS-1:0] left_x;
	logic [COORD_BITS-1:0] top_y;
	logic [COORD_BITS-1:0] right_x;
	logic [COORD_BITS-1:0] bottom_y;

	modport source (output valid, opcode, left_x, top_y, right_x, bottom_y, input ready);
	modport sink   (input valid, opcode, left_x, top_y, right_x, bottom_y, output ready);
endinterface

interface bonc_res_if import bonc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   status;
	logic                   is_negative;
	logic [BOX_COUNT_W-1:0] box_count;

	modport source (output valid, status, is_negative, box_count, input ready);
	modport sink   (input valid, status, is_negative, box_count, output ready);
endinterface

>>> hdl/box_overlap_negative_check_core.sv
// Top level of the box overlap negative check block: box table, sequencer
// and the shared overlap unit. Depends on bonc_pkg and bonc_if.
//
// Use: words arrive on cmd (opcode plus one box in inclusive corners).
// A clear empties the table, a load appends the box (dropped with status
// set when the table is full), a query tests the box against every stored
// box for intersection-over-union above 0.3 and reports is_negative.
// Each command word gives exactly one result word on res, which also
// carries the number of stored boxes.
// Timing: clear, load, unused opcodes and a query on an empty table go
// from accept straight to the result hand-off; any other query runs the
// overlap unit, which visits one stored box per cycle through the single
// table read port, and hands off once its pipe has drained.
// cmd is not ready while a word is in work.
// The result sits in an output register; cmd is accepted again while a
// result waits, but the next result is held back until res is taken.
// Reset empties the table (count to zero) and drops any pending result;
// table contents are not cleared.
module box_overlap_negative_check_core import bonc_pkg::*; #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 13
) (
	input  logic       clk,
	input  logic       arst_n,
	bonc_cmd_if.sink   cmd,
	bonc_res_if.source res
);

	localparam int C     = COORD_BITS;
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int BOX_W = 4 * C;
	localparam int DW    = C + 2;         // signed side length
	localparam int MW    = C + 1;         // clamped overlap length
	localparam int AW    = 2 * DW;        // signed area
	localparam int IW    = 2 * MW;        // intersection area
	localparam int UW    = AW + 2;        // union
	localparam int TW    = IW + 4;        // 10 * intersection
	localparam int CW    = UW + 3;        // compare width

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [C-1:0]       c_lx_q, c_ty_q, c_rx_q, c_by_q;
	logic               neg_q;
	logic               status_q;
	logic               res_valid_q;
	logic               res_status_q;
	logic               res_neg_q;
	logic [BOX_COUNT_W-1:0] res_count_q;

	logic [BOX_W-1:0]   mem [MAX_BOXES];
	logic               mem_we;
	logic [BOX_W-1:0]   mem_wdata;

	logic               full;
	logic               last_idx;

	// overlap pipe
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [BOX_W-1:0]   gt_s1;
	logic [MW-1:0]      w_s2, h_s2;
	logic signed [DW-1:0] gw_s2, gh_s2;
	logic [IW-1:0]      inter_s3;
	logic signed [AW-1:0] a1_s3;
	logic signed [AW-1:0] a2_q;
	logic signed [UW-1:0] uni_s4;
	logic [TW-1:0]      ten_s4;

	logic [C-1:0]       g_lx, g_ty, g_rx, g_by;
	logic [C-1:0]       x1, y1, x2, y2;
	logic signed [DW-1:0] w_raw, h_raw, gw, gh, cw, ch;
	logic signed [CW-1:0] ten_ext, three_uni;
	logic               hit;

	assign full     = (count_q == CNT_W'(MAX_BOXES));
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	assign cmd.ready       = (state_q == ST_IDLE);
	assign res.valid       = res_valid_q;
	assign res.status      = res_status_q;
	assign res.is_negative = res_neg_q;
	assign res.box_count   = res_count_q;

	// table: one write port, one registered read port
	assign mem_we    = cmd.valid && cmd.ready && (op_t'(cmd.opcode) == OP_LOAD) && !full;
	assign mem_wdata = {cmd.bottom_y, cmd.right_x, cmd.top_y, cmd.left_x};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[count_q[IDX_W-1:0]] <= mem_wdata;
		gt_s1 <= mem[idx_q];
	end

	// overlap geometry against the held candidate
	always_comb begin
		g_lx  = gt_s1[C-1:0];
		g_ty  = gt_s1[2*C-1:C];
		g_rx  = gt_s1[3*C-1:2*C];
		g_by  = gt_s1[4*C-1:3*C];
		x1    = (g_lx > c_lx_q) ? g_lx : c_lx_q;
		y1    = (g_ty > c_ty_q) ? g_ty : c_ty_q;
		x2    = (g_rx < c_rx_q) ? g_rx : c_rx_q;
		y2    = (g_by < c_by_q) ? g_by : c_by_q;
		w_raw = signed'({2'b00, x2}) - signed'({2'b00, x1}) + DW'(1);
		h_raw = signed'({2'b00, y2}) - signed'({2'b00, y1}) + DW'(1);
		gw    = signed'({2'b00, g_rx}) - signed'({2'b00, g_lx}) + DW'(1);
		gh    = signed'({2'b00, g_by}) - signed'({2'b00, g_ty}) + DW'(1);
		cw    = signed'({2'b00, c_rx_q}) - signed'({2'b00, c_lx_q}) + DW'(1);
		ch    = signed'({2'b00, c_by_q}) - signed'({2'b00, c_ty_q}) + DW'(1);
	end

	// 10*inter > 3*union, only for a positive union
	always_comb begin
		ten_ext   = CW'(signed'({1'b0, ten_s4}));
		three_uni = (CW'(uni_s4) <<< 1) + CW'(uni_s4);
		hit       = (uni_s4 > UW'(0)) && (ten_ext > three_uni);
	end

	always_ff @(posedge clk) begin
		w_s2     <= (w_raw < DW'(0)) ? MW'(0) : w_raw[MW-1:0];
		h_s2     <= (h_raw < DW'(0)) ? MW'(0) : h_raw[MW-1:0];
		gw_s2    <= gw;
		gh_s2    <= gh;
		inter_s3 <= IW'(w_s2) * IW'(h_s2);
		a1_s3    <= AW'(gw_s2) * AW'(gh_s2);
		a2_q     <= AW'(cw) * AW'(ch);
		uni_s4   <= UW'(a1_s3) + UW'(a2_q) - UW'(signed'({1'b0, inter_s3}));
		ten_s4   <= (TW'(inter_s3) << 3) + (TW'(inter_s3) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			c_lx_q       <= '0;
			c_ty_q       <= '0;
			c_rx_q       <= '0;
			c_by_q       <= '0;
			neg_q        <= 1'b0;
			status_q     <= STATUS_DONE;
			res_valid_q  <= 1'b0;
			res_status_q <= STATUS_DONE;
			res_neg_q    <= 1'b0;
			res_count_q  <= '0;
		end else begin
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			if (v_s4 && hit)
				neg_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						c_lx_q   <= cmd.left_x;
						c_ty_q   <= cmd.top_y;
						c_rx_q   <= cmd.right_x;
						c_by_q   <= cmd.bottom_y;
						idx_q    <= '0;
						status_q <= STATUS_DONE;
						neg_q    <= 1'b0;
						state_q  <= ST_DONE;
						case (op_t'(cmd.opcode))
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_LOAD: begin
								if (full)
									status_q <= STATUS_FULL;
								else
									count_q <= count_q + CNT_W'(1);
							end
							OP_QUERY: begin
								neg_q <= 1'b1;
								if (count_q != '0)
									state_q <= ST_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (last_idx)
						state_q <= ST_DRAIN;
					else
						idx_q <= idx_q + IDX_W'(1);
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3 && !v_s4)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_neg_q    <= neg_q;
						res_count_q  <= BOX_COUNT_W'(count_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/bonc_checker.sv
// Port-level checks for the box overlap negative check block, with the
// bind that attaches them to the top level. Depends on bonc_pkg.
module bonc_checker import bonc_pkg::*; #(
	parameter int MAX_BOXES = 64
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_ready,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic                   res_status,
	input logic                   res_is_negative,
	input logic [BOX_COUNT_W-1:0] res_box_count
);

	// a stalled result word stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn while stalled");

	// cmd drops ready once a command word is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted in back-to-back cycles");

	// a dropped load only happens on a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == STATUS_FULL) |->
			res_box_count == BOX_COUNT_W'(MAX_BOXES))
		else $error("load dropped with table not full");

	// a dropped load is never a query answer
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !((res_status == STATUS_FULL) && res_is_negative))
		else $error("full status together with negative flag");

endmodule

bind box_overlap_negative_check_core bonc_checker #(.MAX_BOXES(MAX_BOXES)) u_bonc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_is_negative (res.is_negative),
	.res_box_count   (res.box_count)
);
